>>> rtl/fee_pkg.sv
// Shared constants and helpers for the epipolar error pipeline.
package fee_pkg;

    // Quotient bits of the squared distance (unsigned Q32.16).
    localparam int QW = 48;
    // Fraction bits of a coordinate.
    localparam int FRAC = 16;
    // Width of a coefficient (signed Q8.24).
    localparam int COEF_W = 32;
    // Configuration register index width and indices.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_WORD_4 = 3'd4;

    // Matrix entry used by a line term. Lane 0 builds F*p1 (rows of F),
    // lane 1 builds F^T*p2 (columns of F). Term 0 multiplies x, term 1
    // multiplies y, term 2 is the constant.
    function automatic int coef_idx(input int lane, input int row, input int term);
        if (lane == 0) begin
            return 3 * row + term;
        end
        return row + 3 * term;
    endfunction

endpackage

>>> rtl/fee_in_if.sv
// Input channel: one point correspondence per item.
interface fee_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;

    modport source (output valid, first_x, first_y, second_x, second_y, input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

>>> rtl/fee_out_if.sv
// Output channel: one error result per item.
interface fee_out_if;
    logic                  valid;
    logic                  ready;
    logic [fee_pkg::QW-1:0] max_sq_distance;
    logic                  degenerate_or_overflow;

    modport source (output valid, max_sq_distance, degenerate_or_overflow, input ready);
    modport sink   (input valid, max_sq_distance, degenerate_or_overflow, output ready);
endinterface

>>> rtl/fee_cfg_if.sv
// Configuration write channel.
interface fee_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fee_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/fundamental_epipolar_error_unit.sv
// Symmetric epipolar error of point correspondences under a fundamental matrix.
// Takes one correspondence per clock unless the output is held and returns
// one result per item via these stages: input, coefficient products, line sums,
// a five-stage multiplier for the line norms and point dot products, their sums,
// a second five-stage multiplier that squares the dot product, an overflow
// check, one restoring division stage per quotient bit (48) and the output
// register. Each stage holds its item until the next one is free, so gaps
// downstream are filled and nothing is dropped. A zero-length line or a
// quotient of 2^48 or more gives 2^48-1 and sets the flag. Coefficients must be
// written through the configuration channel while idle; the unit does not check.
module fundamental_epipolar_error_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fee_in_if.sink   i_in,
    fee_cfg_if.sink  i_cfg,
    fee_out_if.source o_out
);
    localparam int CW    = COORD_WIDTH;
    localparam int QW    = fee_pkg::QW;
    localparam int FRAC  = fee_pkg::FRAC;
    localparam int FW    = fee_pkg::COEF_W;
    localparam int PRW   = CW + FW;
    localparam int LW    = CW + FW + 2;
    localparam int DW    = CW + LW + 2;
    localparam int NNW   = 2 * LW + 1;
    localparam int DNW   = NNW + FRAC;
    localparam int NUMW  = 2 * DW;
    localparam int RMW   = (NUMW > DNW + QW) ? NUMW : DNW + QW;

    localparam int S_MUL1 = 3;
    localparam int S_ND   = 8;
    localparam int S_MUL2 = 9;
    localparam int S_SAT  = 14;
    localparam int S_DIV  = 15;
    localparam int S_OUT  = S_DIV + QW;
    localparam int NST    = S_OUT + 1;

    logic [63:0]           r_coef0, r_coef1, r_coef2, r_coef3;
    logic [31:0]           r_coef4;
    logic signed [FW-1:0]  w_f [9];

    logic [NST-1:0]        r_v;
    logic [NST:0]          w_en;

    logic signed [CW-1:0]  r_pt0 [4];
    logic signed [CW-1:0]  r_pt1 [4];
    logic signed [CW-1:0]  r_pt2 [4];
    logic signed [PRW-1:0] r_pr [2][3][2];
    logic signed [LW-1:0]  r_ln [2][3];
    logic signed [LW-1:0]  r_cd [2][5];
    logic signed [2*LW-1:0] w_aa [2];
    logic signed [2*LW-1:0] w_bb [2];
    logic signed [CW+LW-1:0] w_xa [2];
    logic signed [CW+LW-1:0] w_yb [2];
    logic [NNW-1:0]        r_n [2];
    logic signed [DW-1:0]  r_d [2];
    logic [DNW-1:0]        r_dn [2][5];
    logic signed [NUMW-1:0] w_sq [2];
    logic [RMW-1:0]        r_rem [2][QW+1];
    logic [DNW-1:0]        r_den [2][QW+1];
    logic [QW-1:0]         r_q [2][QW+1];
    logic                  r_sat [2][QW+1];
    logic [QW-1:0]         w_e [2];
    logic [QW-1:0]         r_max;
    logic                  r_flag;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef0 <= '0;
            r_coef1 <= '0;
            r_coef2 <= '0;
            r_coef3 <= '0;
            r_coef4 <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                fee_pkg::REG_COEF_WORD_0: r_coef0 <= i_cfg.data;
                fee_pkg::REG_COEF_WORD_1: r_coef1 <= i_cfg.data;
                fee_pkg::REG_COEF_WORD_2: r_coef2 <= i_cfg.data;
                fee_pkg::REG_COEF_WORD_3: r_coef3 <= i_cfg.data;
                fee_pkg::REG_COEF_WORD_4: r_coef4 <= i_cfg.data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_f[0] = signed'(r_coef0[31:0]);
        w_f[1] = signed'(r_coef0[63:32]);
        w_f[2] = signed'(r_coef1[31:0]);
        w_f[3] = signed'(r_coef1[63:32]);
        w_f[4] = signed'(r_coef2[31:0]);
        w_f[5] = signed'(r_coef2[63:32]);
        w_f[6] = signed'(r_coef3[31:0]);
        w_f[7] = signed'(r_coef3[63:32]);
        w_f[8] = signed'(r_coef4);
    end

    // Stage enables: a stage advances when empty or when the next one advances.
    assign w_en[NST] = o_out.ready;
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end
    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Input, products and line sums.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pt0[0] <= i_in.first_x;
            r_pt0[1] <= i_in.first_y;
            r_pt0[2] <= i_in.second_x;
            r_pt0[3] <= i_in.second_y;
        end
        if (w_en[1]) begin
            r_pt1 <= r_pt0;
        end
        if (w_en[2]) begin
            r_pt2 <= r_pt1;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        for (genvar r = 0; r < 3; r++) begin : g_row
            for (genvar t = 0; t < 2; t++) begin : g_term
                always_ff @(posedge i_clk) begin
                    if (w_en[1]) begin
                        r_pr[l][r][t] <= PRW'(w_f[fee_pkg::coef_idx(l, r, t)])
                                       * PRW'(r_pt0[2*l+t]);
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_en[2]) begin
                    r_ln[l][r] <= LW'(r_pr[l][r][0]) + LW'(r_pr[l][r][1])
                                + (LW'(w_f[fee_pkg::coef_idx(l, r, 2)]) <<< FRAC);
                end
            end
        end

        // Norm and dot-product multipliers; lane 0 measures the second point.
        fee_mul #(.AW(LW), .BW(LW)) u_aa (
            .i_clk (i_clk), .i_en (w_en[S_MUL1+4:S_MUL1]),
            .i_a (r_ln[l][0]), .i_b (r_ln[l][0]), .o_p (w_aa[l])
        );
        fee_mul #(.AW(LW), .BW(LW)) u_bb (
            .i_clk (i_clk), .i_en (w_en[S_MUL1+4:S_MUL1]),
            .i_a (r_ln[l][1]), .i_b (r_ln[l][1]), .o_p (w_bb[l])
        );
        fee_mul #(.AW(LW), .BW(CW)) u_xa (
            .i_clk (i_clk), .i_en (w_en[S_MUL1+4:S_MUL1]),
            .i_a (r_ln[l][0]), .i_b (r_pt2[2-2*l]), .o_p (w_xa[l])
        );
        fee_mul #(.AW(LW), .BW(CW)) u_yb (
            .i_clk (i_clk), .i_en (w_en[S_MUL1+4:S_MUL1]),
            .i_a (r_ln[l][1]), .i_b (r_pt2[3-2*l]), .o_p (w_yb[l])
        );

        for (genvar s = 0; s < 5; s++) begin : g_cdel
            always_ff @(posedge i_clk) begin
                if (w_en[S_MUL1+s]) begin
                    r_cd[l][s] <= (s == 0) ? r_ln[l][2] : r_cd[l][(s == 0) ? 0 : s-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[S_ND]) begin
                r_n[l] <= NNW'($unsigned(w_aa[l])) + NNW'($unsigned(w_bb[l]));
                r_d[l] <= DW'(w_xa[l]) + DW'(w_yb[l]) + (DW'(r_cd[l][4]) <<< FRAC);
            end
        end

        fee_mul #(.AW(DW), .BW(DW)) u_sq (
            .i_clk (i_clk), .i_en (w_en[S_MUL2+4:S_MUL2]),
            .i_a (r_d[l]), .i_b (r_d[l]), .o_p (w_sq[l])
        );

        for (genvar s = 0; s < 5; s++) begin : g_ddel
            always_ff @(posedge i_clk) begin
                if (w_en[S_MUL2+s]) begin
                    r_dn[l][s] <= (s == 0) ? (DNW'(r_n[l]) << FRAC)
                                           : r_dn[l][(s == 0) ? 0 : s-1];
                end
            end
        end

        // Overflow check; a zero norm always lands here as well.
        always_ff @(posedge i_clk) begin
            if (w_en[S_SAT]) begin
                r_rem[l][0] <= RMW'($unsigned(w_sq[l]));
                r_den[l][0] <= r_dn[l][4];
                r_sat[l][0] <= RMW'($unsigned(w_sq[l])) >= (RMW'(r_dn[l][4]) << QW);
                r_q[l][0]   <= '0;
            end
        end

        // Restoring division, one quotient bit a stage, most significant first.
        for (genvar s = 0; s < QW; s++) begin : g_div
            logic [RMW-1:0] w_t;
            logic           w_ge;
            logic [QW-1:0]  n_q;

            assign w_t  = RMW'(r_den[l][s]) << (QW - 1 - s);
            assign w_ge = r_rem[l][s] >= w_t;

            always_comb begin
                n_q = r_q[l][s];
                n_q[QW-1-s] = w_ge;
            end

            always_ff @(posedge i_clk) begin
                if (w_en[S_DIV+s]) begin
                    r_rem[l][s+1] <= w_ge ? (r_rem[l][s] - w_t) : r_rem[l][s];
                    r_den[l][s+1] <= r_den[l][s];
                    r_q[l][s+1]   <= n_q;
                    r_sat[l][s+1] <= r_sat[l][s];
                end
            end
        end

        assign w_e[l] = r_sat[l][QW] ? {QW{1'b1}} : r_q[l][QW];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_OUT]) begin
            r_max  <= (w_e[0] > w_e[1]) ? w_e[0] : w_e[1];
            r_flag <= r_sat[0][QW] | r_sat[1][QW];
        end
    end

    assign o_out.valid                  = r_v[S_OUT];
    assign o_out.max_sq_distance        = r_max;
    assign o_out.degenerate_or_overflow = r_flag;
endmodule

>>> rtl/fee_mul.sv
// Five-stage signed multiplier built from 32x32 partial products.
module fee_mul #(
    parameter int AW = 66,
    parameter int BW = 66
) (
    input  logic                    i_clk,
    input  logic [4:0]              i_en,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int LA  = (AW + 31) / 32;
    localparam int LB  = (BW + 31) / 32;
    localparam int RW  = 32 * (LB + 1);
    localparam int PW  = 32 * (LA + LB);
    localparam int PPW = AW + BW;

    logic [AW-1:0]    w_abs_a;
    logic [BW-1:0]    w_abs_b;
    logic [LA*32-1:0] r_ma;
    logic [LB*32-1:0] r_mb;
    logic [3:0]       r_sg;
    logic [63:0]      r_pp [LA][LB];
    logic [RW-1:0]    n_row [LA];
    logic [RW-1:0]    r_row [LA];
    logic [PW-1:0]    n_sum;
    logic [PW-1:0]    r_sum;
    logic [PPW-1:0]   w_mag;
    logic [PPW-1:0]   r_p;

    assign w_abs_a = i_a[AW-1] ? (~i_a + 1'b1) : i_a;
    assign w_abs_b = i_b[BW-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        for (int i = 0; i < LA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < LB; j++) begin
                n_row[i] = n_row[i] + (RW'(r_pp[i][j]) << (32 * j));
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < LA; i++) begin
            n_sum = n_sum + (PW'(r_row[i]) << (32 * i));
        end
    end

    assign w_mag = r_sum[PPW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ma     <= (LA*32)'(w_abs_a);
            r_mb     <= (LB*32)'(w_abs_b);
            r_sg[0]  <= i_a[AW-1] ^ i_b[BW-1];
        end
        if (i_en[1]) begin
            for (int i = 0; i < LA; i++) begin
                for (int j = 0; j < LB; j++) begin
                    r_pp[i][j] <= 64'(r_ma[32*i +: 32]) * 64'(r_mb[32*j +: 32]);
                end
            end
            r_sg[1] <= r_sg[0];
        end
        if (i_en[2]) begin
            r_row   <= n_row;
            r_sg[2] <= r_sg[1];
        end
        if (i_en[3]) begin
            r_sum   <= n_sum;
            r_sg[3] <= r_sg[2];
        end
        if (i_en[4]) begin
            r_p <= r_sg[3] ? (~w_mag + 1'b1) : w_mag;
        end
    end

    assign o_p = signed'(r_p);
endmodule
